// ----- sv/fcpi_pkg.sv -----
// Shared types and constants for the four-channel PI temperature loop.
// Used by the configuration bank, the loop datapath and the top level.
package fcpi_pkg;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_SETPOINT_CH0 = 3'd2,
    REG_SETPOINT_CH1 = 3'd3,
    REG_SETPOINT_CH2 = 3'd4,
    REG_SETPOINT_CH3 = 3'd5
  } reg_idx_t;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 14;
  localparam int SETPOINTS   = 4;
  localparam int CHAN_W      = 2;
  localparam int RAW_W       = 16;
  localparam int TEMP_W      = 13;
  localparam int ERR_W       = 16;
  localparam int INTEG_W     = 24;
  localparam int DRIVE_W     = 19;
  localparam int WARM_W      = 3;

  // Integral limits in 1/16 degree units: 50 degrees above, state width below.
  localparam logic signed [INTEG_W:0] INTEG_CAP = 25'sd800;
  localparam logic signed [INTEG_W:0] INTEG_MIN = -25'sd8388608;

  // Live configuration handed from the register bank to the datapath.
  typedef struct packed {
    logic        [7:0]                      gain_p;
    logic        [7:0]                      gain_i;
    logic signed [SETPOINTS-1:0][CFG_DATA_W-1:0] setpoint;
  } cfg_t;

endpackage

// ----- sv/fcpi_cfg.sv -----
// Configuration register bank: gains and per-channel setpoints.
// Depends on fcpi_pkg for register indexes and the cfg_t bundle.
module fcpi_cfg
  import fcpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; indexes beyond the list leave everything unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_GAIN_P:       cfg_nxt.gain_p      = wr_data[7:0];
        REG_GAIN_I:       cfg_nxt.gain_i      = wr_data[7:0];
        REG_SETPOINT_CH0: cfg_nxt.setpoint[0] = wr_data;
        REG_SETPOINT_CH1: cfg_nxt.setpoint[1] = wr_data;
        REG_SETPOINT_CH2: cfg_nxt.setpoint[2] = wr_data;
        REG_SETPOINT_CH3: cfg_nxt.setpoint[3] = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/fcpi_calc.sv -----
// Loop datapath: warm-up counter, per-channel error and integral state,
// and the PI drive computation. Depends on fcpi_pkg.
module fcpi_calc
  import fcpi_pkg::*;
#(
  parameter int CHANNELS     = 4,
  parameter int WARMUP_ITEMS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [CHAN_W-1:0]  channel,
  input  logic [RAW_W-1:0]   measured_raw,
  input  logic               fan_running,
  input  cfg_t               cfg,
  output logic [DRIVE_W-1:0] drive,
  output logic               warming_up
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic        [WARM_W-1:0]  warm_r;
  logic        [WARM_W-1:0]  warm_nxt;
  logic signed [ERR_W-1:0]   last_err_r [CHANNELS];
  logic signed [INTEG_W-1:0] integ_r    [CHANNELS];

  logic                      in_warmup;
  logic                      ch_ok;
  logic        [IDX_W-1:0]   idx;
  logic        [TEMP_W-1:0]  temp;
  logic signed [CFG_DATA_W-1:0] sp;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   prev;
  logic signed [INTEG_W:0]   acc_raw;
  logic signed [INTEG_W-1:0] acc;
  logic signed [24:0]        prod_p;
  logic signed [32:0]        prod_i;
  logic signed [33:0]        sum;
  logic        [29:0]        quot;

  assign in_warmup = (warm_r < WARM_W'(WARMUP_ITEMS));
  assign ch_ok     = (32'(channel) < 32'(CHANNELS));
  assign idx       = IDX_W'(channel);

  // Error against the channel's setpoint, both in 1/16 degree units.
  assign temp = measured_raw[RAW_W-1:3];
  assign sp   = cfg.setpoint[channel];
  assign err  = $signed({3'b000, temp}) - $signed({{2{sp[CFG_DATA_W-1]}}, sp});
  assign prev = last_err_r[idx];

  // Integral update with clamping; a running fan clears it.
  assign acc_raw = $signed({integ_r[idx][INTEG_W-1], integ_r[idx]})
                 + $signed({{(INTEG_W+1-ERR_W){prev[ERR_W-1]}}, prev});

  always_comb begin
    if (fan_running) begin
      acc = '0;
    end else if (acc_raw >= INTEG_CAP) begin
      acc = INTEG_CAP[INTEG_W-1:0];
    end else if (acc_raw < INTEG_MIN) begin
      acc = INTEG_MIN[INTEG_W-1:0];
    end else begin
      acc = acc_raw[INTEG_W-1:0];
    end
  end

  // Proportional and integral products, then the sum.
  assign prod_p = $signed({17'd0, cfg.gain_p}) * 25'(err);
  assign prod_i = $signed({25'd0, cfg.gain_i}) * 33'(acc);
  assign sum    = $signed({{9{prod_p[24]}}, prod_p}) + $signed({prod_i[32], prod_i});
  assign quot   = sum[33:4];

  // Drive: zero for warm-up, bad channel or non-positive sum; saturate high.
  always_comb begin
    warming_up = 1'b0;
    drive      = '0;
    if (in_warmup) begin
      warming_up = 1'b1;
    end else if (ch_ok && !sum[33] && (sum != '0)) begin
      if (|quot[29:DRIVE_W]) begin
        drive = '1;
      end else begin
        drive = quot[DRIVE_W-1:0];
      end
    end
  end

  assign warm_nxt = in_warmup ? (warm_r + WARM_W'(1)) : warm_r;

  // State update, once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        last_err_r[k] <= '0;
        integ_r[k]    <= '0;
      end
    end else if (en) begin
      warm_r <= warm_nxt;
      if (!in_warmup && ch_ok) begin
        last_err_r[idx] <= err;
        integ_r[idx]    <= acc;
      end
    end
  end

endmodule

// ----- sv/four_channel_pi_temperature_loop.sv -----
// Four-channel PI temperature loop, top level.
// An item passes through the input register, then the result register.
// Throughput: one item per cycle while the result side does not stall,
// set by the single compute pass between the two registers. Reset
// (synchronous, active low) clears the pipeline valid flags, the warm-up
// count, all loop state and the configuration registers.
module four_channel_pi_temperature_loop
  import fcpi_pkg::*;
#(
  parameter int CHANNELS     = 4,
  parameter int WARMUP_ITEMS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAN_W-1:0]     in_channel,
  input  logic [RAW_W-1:0]      in_measured_raw,
  input  logic                  in_fan_running,
  // Result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DRIVE_W-1:0]    out_drive,
  output logic                  out_warming_up,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  logic                s1_valid_r;
  logic [CHAN_W-1:0]   s1_channel_r;
  logic [RAW_W-1:0]    s1_raw_r;
  logic                s1_fan_r;
  logic                out_valid_r;
  logic [DRIVE_W-1:0]  out_drive_r;
  logic                out_warm_r;

  logic                adv;
  logic                in_take;
  logic [DRIVE_W-1:0]  calc_drive;
  logic                calc_warm;

  assign cfg_ready = 1'b1;

  fcpi_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The compute stage moves when the result register is free or being taken.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_channel_r <= in_channel;
      s1_raw_r     <= in_measured_raw;
      s1_fan_r     <= in_fan_running;
    end
  end

  fcpi_calc #(
    .CHANNELS     (CHANNELS),
    .WARMUP_ITEMS (WARMUP_ITEMS)
  ) u_calc (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (s1_valid_r && adv),
    .channel      (s1_channel_r),
    .measured_raw (s1_raw_r),
    .fan_running  (s1_fan_r),
    .cfg          (cfg),
    .drive        (calc_drive),
    .warming_up   (calc_warm)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_drive_r <= calc_drive;
      out_warm_r  <= calc_warm;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive      = out_drive_r;
  assign out_warming_up = out_warm_r;

  // A warm-up result always carries zero drive.
  a_warm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_warming_up |-> out_drive == '0)
    else $error("warm-up item with nonzero drive");

  // The input side only stalls while an item sits in the input register.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // An item leaving the input register shows up as a result next cycle.
  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv |=> out_valid_r)
    else $error("item lost between input and result register");

endmodule

// ----- sim/four_channel_pi_temperature_loop_tb.sv -----
// Self-checking testbench for the four-channel PI temperature loop.
// Depends on fcpi_pkg and four_channel_pi_temperature_loop; it predicts every
// result from its own model of the loop state and checks the results in order.
module four_channel_pi_temperature_loop_tb;
  import fcpi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOOP_CHANNELS = 4;
  localparam int WARMUP_LEN    = 6;

  // Register indexes past the end of the list; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  // Loop limits in 1/16 degree units.
  localparam logic signed [INTEG_W:0] INTEGRAL_CEIL  = 25'sd800;
  localparam logic signed [INTEG_W:0] INTEGRAL_FLOOR = -25'sd8388608;
  localparam longint DRIVE_CEIL = 524287;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               warming_up;
  } loop_result_t;

  // Predicts the drive for each accepted sample and checks results in order.
  class drive_scoreboard;
    logic        [7:0]            gain_p;
    logic        [7:0]            gain_i;
    logic signed [CFG_DATA_W-1:0] setpoint[LOOP_CHANNELS];
    logic        [WARM_W-1:0]     warm_count;
    logic signed [ERR_W-1:0]      prev_err[LOOP_CHANNELS];
    logic signed [INTEG_W-1:0]    integ[LOOP_CHANNELS];
    loop_result_t                 drive_expected[$];
    int                           failures;

    function void clear();
      gain_p     = '0;
      gain_i     = '0;
      warm_count = '0;
      failures   = 0;
      for (int k = 0; k < LOOP_CHANNELS; k++) begin
        setpoint[k] = '0;
        prev_err[k] = '0;
        integ[k]    = '0;
      end
    endfunction

    function int pending();
      return drive_expected.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GAIN_P: gain_p = data[7:0];
        REG_GAIN_I: gain_i = data[7:0];
        REG_SETPOINT_CH0, REG_SETPOINT_CH1, REG_SETPOINT_CH2, REG_SETPOINT_CH3:
          setpoint[idx - REG_SETPOINT_CH0] = data;
        default: ;
      endcase
    endfunction

    // One accepted sample: update the channel's loop state, queue the drive.
    function void note_sample(logic [CHAN_W-1:0] ch, logic [RAW_W-1:0] raw, logic fan);
      loop_result_t            r;
      logic [TEMP_W-1:0]       temp;
      logic signed [ERR_W-1:0] err;
      logic signed [INTEG_W:0] acc;
      longint                  sum;
      r = '0;
      if (warm_count < WARMUP_LEN) begin
        // Warm-up: only the shared counter moves.
        warm_count   = warm_count + 1'b1;
        r.warming_up = 1'b1;
      end else if (ch < LOOP_CHANNELS) begin
        temp = raw[RAW_W-1:3];
        err  = $signed({3'b000, temp}) - setpoint[ch];
        acc  = integ[ch] + prev_err[ch];
        if (acc >= INTEGRAL_CEIL) acc = INTEGRAL_CEIL;
        if (acc < INTEGRAL_FLOOR) acc = INTEGRAL_FLOOR;
        if (fan) acc = '0;
        prev_err[ch] = err;
        integ[ch]    = acc[INTEG_W-1:0];
        sum = longint'(gain_p) * longint'(err) + longint'(gain_i) * longint'(acc);
        if (sum > 0) begin
          sum = sum / 16;
          if (sum > DRIVE_CEIL) sum = DRIVE_CEIL;
          r.drive = sum[DRIVE_W-1:0];
        end
      end
      drive_expected.push_back(r);
    endfunction

    function void check_result(logic [DRIVE_W-1:0] drive, logic warm);
      loop_result_t want;
      if (drive_expected.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result: drive %0d warming_up %0b", $realtime, drive, warm);
        return;
      end
      want = drive_expected.pop_front();
      if (drive !== want.drive || warm !== want.warming_up) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result mismatch: expected drive %0d warming_up %0b, got %0d %0b",
                   $realtime, want.drive, want.warming_up, drive, warm);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [CHAN_W-1:0]     in_channel;
  logic [RAW_W-1:0]      in_measured_raw;
  logic                  in_fan_running;
  logic                  out_valid;
  logic                  out_stall;
  logic [DRIVE_W-1:0]    out_drive;
  logic                  out_warming_up;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  drive_scoreboard sb;
  int in_gap_max  = 3;
  int out_gap_max = 3;
  int hold_len    = 0;

  four_channel_pi_temperature_loop #(
    .CHANNELS    (LOOP_CHANNELS),
    .WARMUP_ITEMS(WARMUP_LEN)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_channel     (in_channel),
    .in_measured_raw(in_measured_raw),
    .in_fan_running (in_fan_running),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive      (out_drive),
    .out_warming_up (out_warming_up),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check every result the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_drive, out_warming_up);
  end

  // Result side: a random stall before each item, or one long hold when asked.
  initial begin : result_sink
    int wait_cycles;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_len != 0) begin
        wait_cycles = hold_len;
        hold_len    = 0;
      end else begin
        wait_cycles = $urandom_range(out_gap_max, 0);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Writes every register; gains carry random junk in the unused upper bits.
  task automatic program_loop(input logic [7:0] gp, input logic [7:0] gi,
                              input logic [CFG_DATA_W-1:0] sp0, input logic [CFG_DATA_W-1:0] sp1,
                              input logic [CFG_DATA_W-1:0] sp2, input logic [CFG_DATA_W-1:0] sp3);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom_range(16383));
    cfg_write(CFG_IDX_SPARE_A, data);
    data = CFG_DATA_W'($urandom_range(16383));
    cfg_write(CFG_IDX_SPARE_B, data);
    data = CFG_DATA_W'($urandom_range(16383));
    data[7:0] = gp;
    cfg_write(REG_GAIN_P, data);
    data = CFG_DATA_W'($urandom_range(16383));
    data[7:0] = gi;
    cfg_write(REG_GAIN_I, data);
    cfg_write(REG_SETPOINT_CH0, sp0);
    cfg_write(REG_SETPOINT_CH1, sp1);
    cfg_write(REG_SETPOINT_CH2, sp2);
    cfg_write(REG_SETPOINT_CH3, sp3);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(input logic [CHAN_W-1:0] ch, input logic [RAW_W-1:0] raw,
                             input logic fan);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_channel      <= ch;
    in_measured_raw <= raw;
    in_fan_running  <= fan;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(ch, raw, fan);
  endtask

  // Stop offering items and wait for every outstanding result.
  task automatic settle_input();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Raw words: often close to the channel's setpoint so errors change sign.
  function automatic logic [RAW_W-1:0] pick_raw(input logic [CHAN_W-1:0] ch);
    int               t;
    logic [RAW_W-1:0] raw;
    raw = RAW_W'($urandom_range(16'hFFFF));
    case ($urandom_range(3))
      0: begin
        t = int'(sb.setpoint[ch]);
        t = t + int'($urandom_range(64)) - 32;
        if (t < 0) t = 0;
        if (t > 8191) t = 8191;
        raw[RAW_W-1:3] = t[TEMP_W-1:0];
      end
      1: raw = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
      default: ;
    endcase
    return raw;
  endfunction

  function automatic logic [7:0] pick_gain();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_setpoint();
    case ($urandom_range(3))
      0: return 14'h2000;
      1: return 14'h1FFF;
      default: return CFG_DATA_W'($urandom_range(16383));
    endcase
  endfunction

  task automatic random_burst(input int count);
    logic [CHAN_W-1:0] ch;
    repeat (count) begin
      ch = CHAN_W'($urandom_range(3));
      push_sample(ch, pick_raw(ch), $urandom_range(7) == 0);
    end
    settle_input();
  endtask

  initial begin : stimulus
    sb = new;
    sb.clear();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_channel      = '0;
    in_measured_raw = '0;
    in_fan_running  = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Warm-up items, then two items with every register still at reset.
    push_sample(2'd0, 16'h0000, 1'b0);
    push_sample(2'd3, 16'hFFFF, 1'b1);
    push_sample(2'd1, 16'hAAAA, 1'b0);
    push_sample(2'd2, 16'h5555, 1'b1);
    push_sample(2'd0, 16'hFFFF, 1'b0);
    push_sample(2'd3, 16'h0000, 1'b1);
    push_sample(2'd0, 16'hFFFF, 1'b0);
    push_sample(2'd1, 16'h0000, 1'b1);
    settle_input();

    // Full gains, lowest setpoints: largest drive, integral hits its ceiling.
    program_loop(8'd255, 8'd255, 14'h2000, 14'h2000, 14'h2000, 14'h2000);
    push_sample(2'd0, 16'hFFFF, 1'b0);
    push_sample(2'd1, 16'hFFFF, 1'b0);
    push_sample(2'd2, 16'hFFF8, 1'b0);
    push_sample(2'd3, 16'hFFFF, 1'b0);
    push_sample(2'd0, 16'hFFFF, 1'b0);
    push_sample(2'd0, 16'hFFFF, 1'b1);
    settle_input();

    // Highest setpoints: negative and zero errors, negative drive gives zero.
    program_loop(8'd255, 8'd255, 14'h1FFF, 14'h1FFF, 14'h1FFF, 14'h1FFF);
    push_sample(2'd1, 16'h0000, 1'b0);
    push_sample(2'd1, 16'h0007, 1'b0);
    push_sample(2'd2, 16'hFFFF, 1'b0);
    push_sample(2'd3, 16'h0000, 1'b1);
    push_sample(2'd1, 16'hFFFF, 1'b0);
    settle_input();

    // Push channel 0's integral far below zero with no idling on either side.
    in_gap_max  = 0;
    out_gap_max = 0;
    program_loop(8'($urandom_range(255)), 8'd1, 14'h1FFF, pick_setpoint(), pick_setpoint(),
                 pick_setpoint());
    repeat (80) push_sample(2'd0, RAW_W'($urandom_range(63)), 1'b0);
    settle_input();

    // Climb back up: the integral rises but stays below zero, then a running fan clears it.
    program_loop(8'd0, 8'd255, 14'h2000, pick_setpoint(), pick_setpoint(), pick_setpoint());
    repeat (40) push_sample(2'd0, 16'hFFC0 | RAW_W'($urandom_range(63)), 1'b0);
    push_sample(2'd0, 16'hFFFF, 1'b1);
    settle_input();

    // Back-pressure: the result side holds off while items keep coming.
    out_gap_max = 15;
    program_loop(pick_gain(), pick_gain(), pick_setpoint(), pick_setpoint(), pick_setpoint(),
                 pick_setpoint());
    hold_len = 90;
    random_burst(40);

    // Random phases, each with its own settings and idling mix.
    for (int p = 0; p < 9; p++) begin
      in_gap_max  = (p % 3 == 0) ? 0 : 15;
      out_gap_max = (p % 4 == 0) ? 0 : 15;
      program_loop(pick_gain(), pick_gain(), pick_setpoint(), pick_setpoint(), pick_setpoint(),
                   pick_setpoint());
      random_burst(25);
    end

    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
